FILE: sv/adm_pkg.sv
// ----------------------------------------------------------------------------
// adm_pkg - shared types and constants of the arcade drive mixer
// Fixed-point format, register codes and the structs passed between stages.
// ----------------------------------------------------------------------------
package adm_pkg;

  // fixed-point format
  localparam int FracBits = 14;
  localparam int DataW    = 16;            // speed, turn and drive values
  localparam int TrimW    = 15;            // unsigned trim gains
  localparam int MagW     = FracBits + 1;  // magnitude up to one
  localparam int ProdW    = DataW + TrimW + 1;
  localparam int OneInt   = 1 << FracBits;
  localparam int DriveLimit = 32767;

  localparam logic signed [DataW-1:0] OneVal = DataW'(OneInt);
  localparam logic        [MagW-1:0]  OneMag = MagW'(OneInt);

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int DeadW    = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSquareMode = 2'd0,
    CfgDeadband   = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic             square_mode;
    logic [DeadW-1:0] deadband;
  } cfg_t;

  // accepted command
  typedef struct packed {
    logic signed [DataW-1:0] speed;
    logic signed [DataW-1:0] turn;
    logic        [TrimW-1:0] trim_left;
    logic        [TrimW-1:0] trim_right;
  } cmd_t;

  // speed and turn as sign and magnitude after clamp and shaping
  typedef struct packed {
    logic             speed_neg;
    logic [MagW-1:0]  speed_mag;
    logic             turn_neg;
    logic [MagW-1:0]  turn_mag;
    logic [TrimW-1:0] trim_left;
    logic [TrimW-1:0] trim_right;
  } shaped_t;

  // mixed sides with trims already swapped for reverse
  typedef struct packed {
    logic signed [DataW-1:0] left;
    logic signed [DataW-1:0] right;
    logic        [TrimW-1:0] trim_left;
    logic        [TrimW-1:0] trim_right;
  } mixed_t;

  typedef struct packed {
    logic signed [DataW-1:0] left_drive;
    logic signed [DataW-1:0] right_drive;
  } res_t;

endpackage

FILE: sv/adm_in_if.sv
// ----------------------------------------------------------------------------
// adm_in_if - command channel
// Valid/ready channel carrying speed, turn and the two trim gains.
// ----------------------------------------------------------------------------
interface adm_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [adm_pkg::DataW-1:0] speed;
  logic signed [adm_pkg::DataW-1:0] turn;
  logic        [adm_pkg::TrimW-1:0] trim_left;
  logic        [adm_pkg::TrimW-1:0] trim_right;

  modport source (output valid, speed, turn, trim_left, trim_right, input ready);
  modport sink   (input valid, speed, turn, trim_left, trim_right, output ready);
endinterface

FILE: sv/adm_out_if.sv
// ----------------------------------------------------------------------------
// adm_out_if - drive result channel
// Valid/ready channel carrying the left and right drive values.
// ----------------------------------------------------------------------------
interface adm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [adm_pkg::DataW-1:0] left_drive;
  logic signed [adm_pkg::DataW-1:0] right_drive;

  modport source (output valid, left_drive, right_drive, input ready);
  modport sink   (input valid, left_drive, right_drive, output ready);
endinterface

FILE: sv/adm_cfg_if.sv
// ----------------------------------------------------------------------------
// adm_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface adm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [adm_pkg::CfgIdxW-1:0]   index;
  logic [adm_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/adm_cfg_regs.sv
// ----------------------------------------------------------------------------
// adm_cfg_regs - configuration registers
// Square mode and deadband, written through the configuration channel.
// ----------------------------------------------------------------------------
module adm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_valid_i,
  output logic                          wr_ready_o,
  input  logic [adm_pkg::CfgIdxW-1:0]   wr_index_i,
  input  logic [adm_pkg::CfgDataW-1:0]  wr_data_i,
  output adm_pkg::cfg_t                 cfg_o
);

  adm_pkg::cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      unique case (adm_pkg::cfg_idx_e'(wr_index_i))
        adm_pkg::CfgSquareMode: cfg_d.square_mode = wr_data_i[0];
        adm_pkg::CfgDeadband:   cfg_d.deadband    = wr_data_i[adm_pkg::DeadW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/adm_shape.sv
// ----------------------------------------------------------------------------
// adm_shape - clamp and optional squaring
// Two stages: clamp to plus or minus one as sign and magnitude, then optional square.
// ----------------------------------------------------------------------------
module adm_shape (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             square_mode_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  adm_pkg::cmd_t    data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output adm_pkg::shaped_t data_o
);

  typedef struct packed {
    logic                     neg;
    logic [adm_pkg::MagW-1:0] mag;
  } sm_t;

  function automatic sm_t clamp_sm(logic signed [adm_pkg::DataW-1:0] x);
    sm_t                             r;
    logic signed [adm_pkg::DataW-1:0] nx;
    nx    = -x;
    r.neg = x[adm_pkg::DataW-1];
    if (x > adm_pkg::OneVal || x < -adm_pkg::OneVal) begin
      r.mag = adm_pkg::OneMag;
    end else if (r.neg) begin
      r.mag = nx[adm_pkg::MagW-1:0];
    end else begin
      r.mag = x[adm_pkg::MagW-1:0];
    end
    return r;
  endfunction

  logic             v1_q, v2_q, en1, en2;
  adm_pkg::shaped_t s1_q, s1_d, s2_q, s2_d;
  sm_t              cs, ct;
  logic [2*adm_pkg::MagW-1:0] sq_speed, sq_turn;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v2_q;
  assign data_o  = s2_q;

  // stage 1: clamp
  always_comb begin
    cs              = clamp_sm(data_i.speed);
    ct              = clamp_sm(data_i.turn);
    s1_d.speed_neg  = cs.neg;
    s1_d.speed_mag  = cs.mag;
    s1_d.turn_neg   = ct.neg;
    s1_d.turn_mag   = ct.mag;
    s1_d.trim_left  = data_i.trim_left;
    s1_d.trim_right = data_i.trim_right;
  end

  // stage 2: square keeping sign, magnitude stays within one
  always_comb begin
    sq_speed = (2*adm_pkg::MagW)'(s1_q.speed_mag) * (2*adm_pkg::MagW)'(s1_q.speed_mag);
    sq_turn  = (2*adm_pkg::MagW)'(s1_q.turn_mag) * (2*adm_pkg::MagW)'(s1_q.turn_mag);
    s2_d     = s1_q;
    if (square_mode_i) begin
      s2_d.speed_mag = sq_speed[adm_pkg::FracBits +: adm_pkg::MagW];
      s2_d.turn_mag  = sq_turn[adm_pkg::FracBits +: adm_pkg::MagW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) s1_q <= s1_d;
    if (en2 && v1_q)    s2_q <= s2_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (s2_q.speed_mag <= adm_pkg::OneMag && s2_q.turn_mag <= adm_pkg::OneMag))
    else $error("shaped magnitude above one");

endmodule

FILE: sv/adm_mix.sv
// ----------------------------------------------------------------------------
// adm_mix - deadband and arcade mix
// One stage: deadband, four-quadrant mix and trim swap for reverse.
// ----------------------------------------------------------------------------
module adm_mix (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [adm_pkg::DeadW-1:0] deadband_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  adm_pkg::shaped_t          data_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output adm_pkg::mixed_t           data_o
);

  logic            v_q, en;
  adm_pkg::mixed_t m_q, m_d;
  logic signed [adm_pkg::DataW-1:0] s, t, ms, mt;

  function automatic logic signed [adm_pkg::DataW-1:0] to_signed(
    logic neg, logic [adm_pkg::MagW-1:0] mag, logic [adm_pkg::DeadW-1:0] db);
    logic signed [adm_pkg::DataW-1:0] v;
    v = $signed(adm_pkg::DataW'(mag));
    if (adm_pkg::DeadW'(mag) < db) v = '0;
    return neg ? -v : v;
  endfunction

  function automatic logic signed [adm_pkg::DataW-1:0] smax(
    logic signed [adm_pkg::DataW-1:0] a, logic signed [adm_pkg::DataW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  assign en      = !v_q || ready_i;
  assign ready_o = en;
  assign valid_o = v_q;
  assign data_o  = m_q;

  // every branch keeps both sides within one, so no rescale is needed
  always_comb begin
    s  = to_signed(data_i.speed_neg, data_i.speed_mag, deadband_i);
    t  = to_signed(data_i.turn_neg, data_i.turn_mag, deadband_i);
    ms = -s;
    mt = -t;
    if (s > 0) begin
      if (t > 0) begin
        m_d.left  = s - t;
        m_d.right = smax(s, t);
      end else begin
        m_d.left  = smax(s, mt);
        m_d.right = s + t;
      end
    end else begin
      if (t > 0) begin
        m_d.left  = -smax(ms, t);
        m_d.right = s + t;
      end else begin
        m_d.left  = s - t;
        m_d.right = -smax(ms, mt);
      end
    end
    if (s < 0) begin
      m_d.trim_left  = data_i.trim_right;
      m_d.trim_right = data_i.trim_left;
    end else begin
      m_d.trim_left  = data_i.trim_left;
      m_d.trim_right = data_i.trim_right;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) m_q <= m_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> (m_q.left  <= adm_pkg::OneVal && m_q.left  >= -adm_pkg::OneVal &&
             m_q.right <= adm_pkg::OneVal && m_q.right >= -adm_pkg::OneVal))
    else $error("mixed side outside plus or minus one");

endmodule

FILE: sv/adm_trim.sv
// ----------------------------------------------------------------------------
// adm_trim - trim gain and output limit
// Two stages: signed trim products, then arithmetic shift and saturation.
// ----------------------------------------------------------------------------
module adm_trim (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  adm_pkg::mixed_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output adm_pkg::res_t   data_o
);

  localparam logic signed [adm_pkg::ProdW-1:0] Lim = adm_pkg::ProdW'(adm_pkg::DriveLimit);

  logic v1_q, v2_q, en1, en2;
  logic signed [adm_pkg::ProdW-1:0] pl_q, pr_q, pl_d, pr_d, sl, sr;
  adm_pkg::res_t r_q, r_d;

  function automatic logic signed [adm_pkg::DataW-1:0] sat(
    logic signed [adm_pkg::ProdW-1:0] v);
    logic signed [adm_pkg::ProdW-1:0] c;
    c = v;
    if (v > Lim)  c = Lim;
    if (v < -Lim) c = -Lim;
    return c[adm_pkg::DataW-1:0];
  endfunction

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v2_q;
  assign data_o  = r_q;

  always_comb begin
    pl_d = adm_pkg::ProdW'(data_i.left) *
           adm_pkg::ProdW'($signed({1'b0, data_i.trim_left}));
    pr_d = adm_pkg::ProdW'(data_i.right) *
           adm_pkg::ProdW'($signed({1'b0, data_i.trim_right}));
  end

  // shift rounds toward minus infinity
  always_comb begin
    sl            = pl_q >>> adm_pkg::FracBits;
    sr            = pr_q >>> adm_pkg::FracBits;
    r_d.left_drive  = sat(sl);
    r_d.right_drive = sat(sr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      pl_q <= pl_d;
      pr_q <= pr_d;
    end
    if (en2 && v1_q) r_q <= r_d;
  end

endmodule

FILE: sv/arcade_drive_mixer.sv
// ----------------------------------------------------------------------------
// arcade_drive_mixer - arcade drive mixing in Q2.14
// Clamp, optional signed squaring, deadband, four-quadrant mix, trim and limit.
// ----------------------------------------------------------------------------
// channel  dir  payload                                   transfer when
// cmd_i    in   speed, turn, trim_left, trim_right        valid && ready
// res_o    out  left_drive, right_drive                   valid && ready
// cfg_i    in   index (0 square_mode, 1 deadband), data   valid && ready
//
// five register stages: clamp, square, mix, trim product, shift and limit
// one command per cycle while the result side is ready
// each stage loads when empty or when the one after it moves, so bubbles close up
// a held result stalls only the stages behind it; nothing is dropped or repeated
// asynchronous active-low reset empties the pipeline and clears both registers
// configuration is always ready; other indexes are ignored
// ----------------------------------------------------------------------------
module arcade_drive_mixer (
  input  logic      clk_i,
  input  logic      rst_ni,
  adm_in_if.sink    cmd_i,
  adm_out_if.source res_o,
  adm_cfg_if.sink   cfg_i
);

  adm_pkg::cfg_t    cfg;
  adm_pkg::cmd_t    cmd;
  adm_pkg::shaped_t shaped;
  adm_pkg::mixed_t  mixed;
  adm_pkg::res_t    res;

  // handshake between stage groups
  logic sh_valid, sh_ready;
  logic mx_valid, mx_ready;

  assign cmd.speed      = cmd_i.speed;
  assign cmd.turn       = cmd_i.turn;
  assign cmd.trim_left  = cmd_i.trim_left;
  assign cmd.trim_right = cmd_i.trim_right;

  adm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // clamp and squaring
  adm_shape u_shape (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .square_mode_i (cfg.square_mode),
    .valid_i       (cmd_i.valid),
    .ready_o       (cmd_i.ready),
    .data_i        (cmd),
    .valid_o       (sh_valid),
    .ready_i       (sh_ready),
    .data_o        (shaped)
  );

  // deadband, mix and reverse trim swap
  adm_mix u_mix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .deadband_i (cfg.deadband),
    .valid_i    (sh_valid),
    .ready_o    (sh_ready),
    .data_i     (shaped),
    .valid_o    (mx_valid),
    .ready_i    (mx_ready),
    .data_o     (mixed)
  );

  // trim product and output limit; last stage is the output register
  adm_trim u_trim (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mx_valid),
    .ready_o (mx_ready),
    .data_i  (mixed),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (res)
  );

  assign res_o.left_drive  = res.left_drive;
  assign res_o.right_drive = res.right_drive;

  // the limit is symmetric, so the most negative code never leaves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res.left_drive != -16'sd32768 && res.right_drive != -16'sd32768))
    else $error("drive value outside symmetric limit");

  // with the sink taking results the whole pipeline advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.ready |-> (cmd_i.ready && sh_ready && mx_ready))
    else $error("pipeline stalled without back-pressure");

endmodule

FILE: tb/adm_drive_checker.sv
// ----------------------------------------------------------------------------
// adm_drive_checker - drive value predictor and scoreboard
// Watches the command, result and configuration channels, predicts the left
// and right drive for every command transfer and compares result transfers
// against them in order.
// ----------------------------------------------------------------------------
module adm_drive_checker
  import adm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  adm_in_if    cmd_i,
  adm_out_if   res_i,
  adm_cfg_if   cfg_i,
  output int   mismatches_o,
  output int   drives_due_o
);

  cfg_t settings;
  res_t drive_q[$];
  int   fail_cnt = 0;

  assign mismatches_o = fail_cnt;

  // clamp to one, optional signed square, then deadband
  function automatic longint shape_axis(input logic signed [DataW-1:0] raw, input cfg_t k);
    longint v;
    longint a;
    v = raw;
    if (v > OneInt) v = OneInt;
    else if (v < -OneInt) v = -OneInt;
    if (k.square_mode) begin
      a = (v < 0) ? -v : v;
      a = (a * a) >>> FracBits;
      v = (v < 0) ? -a : a;
    end
    if (((v < 0) ? -v : v) < longint'(k.deadband)) v = 0;
    return v;
  endfunction

  // v * one / m, truncated toward zero
  function automatic longint shrink(input longint v, input longint m);
    longint q;
    q = (((v < 0) ? -v : v) <<< FracBits) / m;
    return (v < 0) ? -q : q;
  endfunction

  // floor of the trim product, limited to the symmetric drive range
  function automatic logic signed [DataW-1:0] trim_drive(input longint w,
                                                         input logic [TrimW-1:0] g);
    longint p;
    p = (w * longint'(g)) >>> FracBits;
    if (p > DriveLimit) p = DriveLimit;
    else if (p < -DriveLimit) p = -DriveLimit;
    return DataW'(p);
  endfunction

  function automatic res_t mix_drive(input cmd_t c, input cfg_t k);
    longint s, t, l, r, m;
    logic [TrimW-1:0] gl, gr;
    res_t o;
    s = shape_axis(c.speed, k);
    t = shape_axis(c.turn, k);
    if (s > 0) begin
      if (t > 0) begin
        l = s - t;
        r = (s > t) ? s : t;
      end else begin
        l = (s > -t) ? s : -t;
        r = s + t;
      end
    end else begin
      if (t > 0) begin
        l = -((-s > t) ? -s : t);
        r = s + t;
      end else begin
        l = s - t;
        r = -((-s > -t) ? -s : -t);
      end
    end
    m = (l < 0) ? -l : l;
    if (((r < 0) ? -r : r) > m) m = (r < 0) ? -r : r;
    if (m > OneInt) begin
      l = shrink(l, m);
      r = shrink(r, m);
    end
    gl = c.trim_left;
    gr = c.trim_right;
    if (s < 0) begin
      gl = c.trim_right;
      gr = c.trim_left;
    end
    o.left_drive  = trim_drive(l, gl);
    o.right_drive = trim_drive(r, gr);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t c;
    res_t want;
    if (!rst_ni) begin
      settings = '0;
      drive_q.delete();
    end else begin
      // prediction uses the settings held before this edge
      if (cmd_i.valid && cmd_i.ready) begin
        c.speed      = cmd_i.speed;
        c.turn       = cmd_i.turn;
        c.trim_left  = cmd_i.trim_left;
        c.trim_right = cmd_i.trim_right;
        drive_q.push_back(mix_drive(c, settings));
      end
      if (res_i.valid && res_i.ready) begin
        if (drive_q.size() == 0) begin
          fail_cnt++;
          $display("%0t unexpected result: expected none, actual left %0d right %0d",
                   $time, res_i.left_drive, res_i.right_drive);
        end else begin
          want = drive_q.pop_front();
          if (res_i.left_drive !== want.left_drive) begin
            fail_cnt++;
            $display("%0t left_drive mismatch: expected %0d, actual %0d",
                     $time, want.left_drive, res_i.left_drive);
          end
          if (res_i.right_drive !== want.right_drive) begin
            fail_cnt++;
            $display("%0t right_drive mismatch: expected %0d, actual %0d",
                     $time, want.right_drive, res_i.right_drive);
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CfgSquareMode: settings.square_mode = cfg_i.data[0];
          CfgDeadband:   settings.deadband    = cfg_i.data[DeadW-1:0];
          default: ;
        endcase
      end
    end
    drives_due_o = drive_q.size();
  end

endmodule

FILE: tb/arcade_drive_mixer_tb.sv
// ----------------------------------------------------------------------------
// arcade_drive_mixer_tb - testbench top of the arcade drive mixer
// Drives a directed set of corner commands, then random commands under a
// series of square mode and deadband settings, with random gaps on the
// command side and random back-pressure on the result side. A checker
// beside the block predicts every drive pair and reports mismatches.
// ----------------------------------------------------------------------------
module arcade_drive_mixer_tb;
  import adm_pkg::*;

  localparam int PipeDepth = 5;

  // register indexes the block does not decode, writes must be ignored
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  logic clk;
  logic rst_n;
  logic burst;       // when set the command side sends with no gaps
  int   mismatches;
  int   drives_due;

  adm_in_if  cmd_if ();
  adm_out_if res_if ();
  adm_cfg_if cfg_if ();

  arcade_drive_mixer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  adm_drive_checker u_drive_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd_i        (cmd_if),
    .res_i        (res_if),
    .cfg_i        (cfg_if),
    .mismatches_o (mismatches),
    .drives_due_o (drives_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5000000;
    $display("arcade_drive_mixer_tb: FAIL");
    $finish;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // speed or turn value: full range, unit range, around the deadband edge,
  // near zero, or one of the clamp corners
  function automatic logic signed [DataW-1:0] pick_axis(input int dead);
    int r;
    int near;
    r = $urandom_range(0, 99);
    if (r < 30) return DataW'($urandom);
    if (r < 65) return DataW'(int'($urandom_range(0, 2 * OneInt)) - OneInt);
    if (r < 80) begin
      near = dead + int'($urandom_range(0, 2)) - 1;
      if (near < 0) near = 0;
      return ($urandom_range(0, 1) != 0) ? DataW'(-near) : DataW'(near);
    end
    if (r < 90) return DataW'(int'($urandom_range(0, 400)) - 200);
    case ($urandom_range(0, 6))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return DataW'(OneInt);
      3: return DataW'(-OneInt);
      4: return DataW'(OneInt + 1);
      5: return DataW'(-OneInt - 1);
      default: return '0;
    endcase
  endfunction

  function automatic logic [TrimW-1:0] pick_trim();
    if ($urandom_range(0, 99) < 80) return TrimW'($urandom);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return TrimW'(OneInt);
      default: return TrimW'(1);
    endcase
  endfunction

  // one command transfer, optionally preceded by an idle gap
  task automatic send_command(input cmd_t c);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.speed      <= c.speed;
    cmd_if.turn       <= c.turn;
    cmd_if.trim_left  <= c.trim_left;
    cmd_if.trim_right <= c.trim_right;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
  endtask

  // stop sending and wait until every predicted drive pair has come out,
  // then let the pipeline run empty
  task automatic settle();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    wait (drives_due == 0);
    repeat (PipeDepth + 3) @(posedge clk);
  endtask

  // register write, valid dropped afterwards
  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // program both registers while idle, then a run of random commands
  task automatic run_setting(input logic sq, input int dead, input int n);
    cmd_t c;
    logic [CfgDataW-1:0] w;
    settle();
    // unused upper data bits are filled with noise
    w = CfgDataW'($urandom);
    w[0] = sq;
    write_register(CfgSquareMode, w);
    w = CfgDataW'($urandom);
    w[DeadW-1:0] = DeadW'(dead);
    write_register(CfgDeadband, w);
    for (int i = 0; i < n; i++) begin
      if ((i % 20) == 0) burst = ($urandom_range(0, 3) == 0);
      c.speed      = pick_axis(dead);
      c.turn       = pick_axis(dead);
      c.trim_left  = pick_trim();
      c.trim_right = pick_trim();
      send_command(c);
    end
    burst = 1'b0;
  endtask

  // result side back-pressure: random stalls between stretches of ready
  initial begin
    int hold;
    res_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  initial begin
    burst             = 1'b0;
    rst_n             <= 1'b0;
    cmd_if.valid      <= 1'b0;
    cmd_if.speed      <= '0;
    cmd_if.turn       <= '0;
    cmd_if.trim_left  <= '0;
    cmd_if.trim_right <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CfgSquareMode;
    cfg_if.data       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, relying on the reset settings: no squaring, no deadband
    // clamp of the most negative and most positive inputs
    send_command(cmd_t'{16'sh8000, 16'sd0, 15'h7fff, 15'h7fff});
    send_command(cmd_t'{16'sh7fff, 16'sd0, 15'h4000, 15'h4000});
    // zero speed falls into the reverse branch
    send_command(cmd_t'{16'sd0, 16'sd0, 15'h4000, 15'h4000});
    send_command(cmd_t'{16'sd0, 16'sd5000, 15'h7fff, 15'h0000});
    send_command(cmd_t'{16'sd0, -16'sd5000, 15'h0000, 15'h7fff});
    // zero turn in the forward and reverse branches, trims swap in reverse
    send_command(cmd_t'{16'sd5000, 16'sd0, 15'h4000, 15'h1234});
    send_command(cmd_t'{-16'sd5000, 16'sd0, 15'h1234, 15'h4000});
    // all four quadrants at full scale
    send_command(cmd_t'{16'sd16384, 16'sd16384, 15'h7fff, 15'h7fff});
    send_command(cmd_t'{-16'sd16384, -16'sd16384, 15'h7fff, 15'h7fff});
    send_command(cmd_t'{16'sd16384, -16'sd16384, 15'h7fff, 15'h7fff});
    send_command(cmd_t'{-16'sd16384, 16'sd16384, 15'h7fff, 15'h7fff});
    send_command(cmd_t'{16'sh7fff, 16'sh8000, 15'h5555, 15'h2aaa});
    // negative trim products round toward minus infinity
    send_command(cmd_t'{-16'sd1, 16'sd1, 15'h7fff, 15'h7fff});
    send_command(cmd_t'{16'sd1, -16'sd1, 15'h0001, 15'h0001});
    send_command(cmd_t'{-16'sd3, 16'sh8000, 15'h0000, 15'h0000});
    send_command(cmd_t'{16'sd12000, 16'sd9000, 15'h3fff, 15'h5000});

    // writes to undecoded indexes leave the settings alone
    settle();
    write_register(CfgSpareA, 16'hffff);
    write_register(CfgSpareB, 16'hffff);
    send_command(cmd_t'{16'sd300, -16'sd200, 15'h4000, 15'h4000});
    send_command(cmd_t'{-16'sd200, -16'sd300, 15'h6000, 15'h2000});

    // random part across settings; each change first waits for an empty
    // pipeline, which also gives the full drain under back-pressure
    run_setting(1'b1, 0, 66);
    run_setting(1'b0, OneInt, 66);
    run_setting(1'b1, OneInt, 66);
    run_setting(1'b0, $urandom_range(1, 4000), 66);
    run_setting(1'b1, $urandom_range(1, OneInt - 1), 66);
    run_setting(1'b0, 1, 66);
    run_setting(1'b1, $urandom_range(8000, OneInt), 66);
    run_setting(1'b0, 0, 66);

    settle();
    if (mismatches == 0) begin
      $display("arcade_drive_mixer_tb: PASS");
    end else begin
      $display("arcade_drive_mixer_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: arcade_drive_mixer.f
sv/adm_pkg.sv
sv/adm_in_if.sv
sv/adm_out_if.sv
sv/adm_cfg_if.sv
sv/adm_cfg_regs.sv
sv/adm_shape.sv
sv/adm_mix.sv
sv/adm_trim.sv
sv/arcade_drive_mixer.sv
tb/adm_drive_checker.sv
tb/arcade_drive_mixer_tb.sv
